[sv/oadsr_pkg.sv]
package oadsr_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int PHASE_BITS       = 24;
    localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);

    localparam int ENV_W      = 16;
    localparam int SMP_W      = 16;
    localparam int RATE_W     = 24;
    localparam int STEP_W     = 23;
    localparam int PROG_FRAC  = 24;
    localparam int PROG_W     = PROG_FRAC + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [PROG_W-1:0] PROG_ONE = PROG_W'(1) << PROG_FRAC;
    localparam logic [ENV_W-1:0]  ENV_FULL = '1;

    localparam logic [16:0] SIN_C0  = 17'd102944;
    localparam logic [16:0] SIN_C1  = 17'd42334;
    localparam logic [16:0] SIN_C2  = 17'd5223;
    localparam logic [16:0] SIN_C3  = 17'd307;
    localparam logic [16:0] SIN_AMP = 17'd32767;

    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_NOTE_ON  = 2'd1;
    localparam logic [1:0] REQ_NOTE_OFF = 2'd2;

    localparam logic [2:0] WAVE_SINE   = 3'd0;
    localparam logic [2:0] WAVE_TRI    = 3'd1;
    localparam logic [2:0] WAVE_SQUARE = 3'd2;
    localparam logic [2:0] WAVE_SAW    = 3'd3;
    localparam logic [2:0] WAVE_PULSE  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd6;

    typedef enum logic [2:0] {
        ENV_IDLE    = 3'd0,
        ENV_ATTACK  = 3'd1,
        ENV_DECAY   = 3'd2,
        ENV_SUSTAIN = 3'd3,
        ENV_RELEASE = 3'd4
    } t_env_stage;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENV,
        ST_SQ,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_P4,
        ST_P5,
        ST_P6,
        ST_VOL,
        ST_GAIN,
        ST_SCALE,
        ST_ADV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_op;

endpackage

[sv/oadsr_if.sv]
interface oadsr_req_if import oadsr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [STEP_W-1:0] note_phase_step;

    modport source (output valid, output req_type, output note_phase_step, input ready);
    modport sink   (input valid, input req_type, input note_phase_step, output ready);
endinterface

interface oadsr_smp_if import oadsr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample_out;
    logic [ENV_W-1:0]        env_level;
    logic [2:0]              env_stage;

    modport source (output valid, output sample_out, output env_level, output env_stage,
                    input ready);
    modport sink   (input valid, input sample_out, input env_level, input env_stage,
                    output ready);
endinterface

interface oadsr_cfg_if import oadsr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/oscillator_with_adsr_envelope.sv]
// Phase-accumulator oscillator with an ADSR envelope.
// The request channel takes three kinds of beats: a sample tick, a note-on that
// carries the phase step, and a note-off. Only a tick produces a beat on the
// sample channel, carrying the signed sample, the envelope level applied to it
// and the envelope stage at that sample.
// All arithmetic runs through one registered multiplier under a small sequencer.
// A tick runs one sequence of steps with the triangle, square, saw and
// pulse waveforms and a longer one with the sine, whose seventh-order
// polynomial adds the steps P1 to P6. Note-on and note-off never leave idle.
// The request channel is ready only while the sequencer is idle.
// Finished samples wait in an output register, so the next request is taken
// while a sample is still pending; a tick that finishes while the previous
// sample has not been taken holds in its last step until the sink accepts it.
// The configuration channel is always ready and should be written only while
// no tick is in progress.
// Reset is synchronous and active low: it restores the register defaults,
// clears the phase and envelope and empties the output register.
module oscillator_with_adsr_envelope import oadsr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    oadsr_req_if.sink   i_req,
    oadsr_smp_if.source o_smp,
    oadsr_cfg_if.sink   i_cfg
);

    t_state r_state, n_state;

    logic [2:0]            r_wave_sel;
    logic [15:0]           r_pulse_width;
    logic [15:0]           r_volume;
    logic [ENV_W-1:0]      r_sustain;
    logic [RATE_W-1:0]     r_attack;
    logic [RATE_W-1:0]     r_decay;
    logic [RATE_W-1:0]     r_release;

    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] r_step;
    t_env_stage            r_stage;
    logic [ENV_W-1:0]      r_env_value;
    logic [ENV_W-1:0]      r_rel_start;
    logic [PROG_W-1:0]     r_prog;

    logic [ENV_W-1:0]      r_env;
    logic [14:0]           r_t2;
    logic [15:0]           r_mag;
    logic                  r_neg;
    logic [SMP_W-1:0]      r_sample;

    logic                  r_out_valid;
    logic [SMP_W-1:0]      r_out_sample;
    logic [ENV_W-1:0]      r_out_env;
    t_env_stage            r_out_stage;

    t_mul_op               w_mul_op;
    t_mul_op               w_env_op;
    logic [MUL_P_W-1:0]    w_prod;
    logic [16:0]           w_sh14;
    logic [32:0]           w_rnd;
    logic [16:0]           w_amp;
    logic [15:0]           w_scaled;
    logic [ENV_W-1:0]      w_env_now;
    logic [ENV_W-1:0]      w_env_prod;

    logic [15:0]           w_p16;
    logic signed [17:0]    w_p18;
    logic [15:0]           w_u;
    logic [14:0]           w_t;
    logic signed [17:0]    w_wave;
    logic [15:0]           w_mag;

    logic [31:0]           w_step32;
    logic [PHASE_BITS-1:0] w_step;
    logic                  w_has_rate;
    logic [RATE_W-1:0]     w_rate;
    logic [PROG_W-1:0]     w_prog_sum;
    logic [PROG_W-1:0]     w_prog_next;
    logic                  w_out_free;

    oadsr_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (w_mul_op),
        .o_prod (w_prod)
    );

    assign w_sh14     = w_prod[30:14];
    assign w_rnd      = 33'(w_prod[31:0]) + 33'd32768;
    assign w_amp      = w_rnd[32:16];
    assign w_scaled   = w_prod[47:32];
    assign w_env_prod = w_prod[PROG_FRAC +: ENV_W];

    assign w_p16 = r_phase[PHASE_BITS-1 -: 16];
    assign w_p18 = signed'({2'b00, w_p16});
    assign w_u   = 16'(r_phase[PHASE_BITS-1 -: SINE_IDX_BITS]) << (16 - SINE_IDX_BITS);
    assign w_t   = w_u[14] ? (15'd16384 - {1'b0, w_u[13:0]}) : {1'b0, w_u[13:0]};

    assign w_step32 = {1'b0, i_req.note_phase_step, 8'b0};
    assign w_step   = w_step32[31 -: PHASE_BITS];

    assign w_out_free = !r_out_valid || o_smp.ready;

    always_comb begin
        w_wave = '0;
        case (r_wave_sel)
            WAVE_TRI: begin
                if (!w_p16[15]) begin
                    w_wave = (w_p18 <<< 1) - 18'sd32768;
                end else begin
                    w_wave = 18'sd98304 - (w_p18 <<< 1);
                end
                if (w_wave > 18'sd32767) begin
                    w_wave = 18'sd32767;
                end
            end
            WAVE_SQUARE: w_wave = w_p16[15] ? -18'sd32767 : 18'sd32767;
            WAVE_SAW:    w_wave = w_p18 - 18'sd32768;
            WAVE_PULSE:  w_wave = (w_p16 < r_pulse_width) ? 18'sd32767 : -18'sd32767;
            default:     w_wave = '0;
        endcase
    end

    assign w_mag = w_wave[17] ? 16'(-w_wave) : 16'(w_wave);

    always_comb begin
        w_env_op = '0;
        case (r_stage)
            ENV_ATTACK: begin
                w_env_op.a = MUL_A_W'(ENV_FULL - r_env_value);
                w_env_op.b = MUL_B_W'(r_prog);
            end
            ENV_DECAY: begin
                w_env_op.a = MUL_A_W'(ENV_FULL - r_sustain);
                w_env_op.b = MUL_B_W'(r_prog);
            end
            ENV_RELEASE: begin
                w_env_op.a = MUL_A_W'(r_rel_start);
                w_env_op.b = MUL_B_W'(PROG_ONE - r_prog);
            end
            default: w_env_op = '0;
        endcase
    end

    always_comb begin
        case (r_stage)
            ENV_ATTACK:  w_env_now = r_env_value + w_env_prod;
            ENV_DECAY:   w_env_now = ENV_FULL - w_env_prod;
            ENV_SUSTAIN: w_env_now = r_sustain;
            ENV_RELEASE: w_env_now = w_env_prod;
            default:     w_env_now = '0;
        endcase
    end

    always_comb begin
        w_has_rate = 1'b1;
        case (r_stage)
            ENV_ATTACK:  w_rate = r_attack;
            ENV_DECAY:   w_rate = r_decay;
            ENV_RELEASE: w_rate = r_release;
            default: begin
                w_rate     = '0;
                w_has_rate = 1'b0;
            end
        endcase
        w_prog_sum = r_prog + PROG_W'(w_rate);
        if (w_rate == '0 || w_prog_sum > PROG_ONE) begin
            w_prog_next = PROG_ONE;
        end else begin
            w_prog_next = w_prog_sum;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid && i_req.req_type == REQ_TICK) begin
                    n_state = ST_ENV;
                end
            end
            ST_ENV:   n_state = ST_SQ;
            ST_SQ:    n_state = (r_wave_sel == WAVE_SINE) ? ST_P1 : ST_VOL;
            ST_P1:    n_state = ST_P2;
            ST_P2:    n_state = ST_P3;
            ST_P3:    n_state = ST_P4;
            ST_P4:    n_state = ST_P5;
            ST_P5:    n_state = ST_P6;
            ST_P6:    n_state = ST_VOL;
            ST_VOL:   n_state = ST_GAIN;
            ST_GAIN:  n_state = ST_SCALE;
            ST_SCALE: n_state = ST_ADV;
            ST_ADV:   n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = (r_state == ST_IDLE);
        w_mul_op    = w_env_op;
        case (r_state)
            ST_SQ: begin
                w_mul_op.a = MUL_A_W'(w_t);
                w_mul_op.b = MUL_B_W'(w_t);
            end
            ST_P1: begin
                w_mul_op.a = MUL_A_W'(w_sh14);
                w_mul_op.b = MUL_B_W'(SIN_C3);
            end
            ST_P2: begin
                w_mul_op.a = MUL_A_W'(r_t2);
                w_mul_op.b = MUL_B_W'(SIN_C2 - w_sh14);
            end
            ST_P3: begin
                w_mul_op.a = MUL_A_W'(r_t2);
                w_mul_op.b = MUL_B_W'(SIN_C1 - w_sh14);
            end
            ST_P4: begin
                w_mul_op.a = MUL_A_W'(w_t);
                w_mul_op.b = MUL_B_W'(SIN_C0 - w_sh14);
            end
            ST_P5: begin
                w_mul_op.a = MUL_A_W'(w_sh14);
                w_mul_op.b = MUL_B_W'(SIN_AMP);
            end
            ST_VOL: begin
                w_mul_op.a = MUL_A_W'(r_mag);
                w_mul_op.b = MUL_B_W'(r_volume);
            end
            ST_GAIN: begin
                w_mul_op.a = w_prod[MUL_A_W-1:0];
                w_mul_op.b = MUL_B_W'(r_env);
            end
            default: w_mul_op = w_env_op;
        endcase
    end

    assign i_cfg.ready      = 1'b1;
    assign o_smp.valid      = r_out_valid;
    assign o_smp.sample_out = signed'(r_out_sample);
    assign o_smp.env_level  = r_out_env;
    assign o_smp.env_stage  = r_out_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_wave_sel    <= WAVE_SINE;
            r_pulse_width <= 16'd32768;
            r_volume      <= 16'd32768;
            r_sustain     <= 16'd45875;
            r_attack      <= 24'd1000;
            r_decay       <= 24'd1000;
            r_release     <= 24'd500;
            r_phase       <= '0;
            r_step        <= '0;
            r_stage       <= ENV_IDLE;
            r_env_value   <= '0;
            r_rel_start   <= '0;
            r_prog        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_WAVE:    r_wave_sel    <= i_cfg.data[2:0];
                    CFG_PULSE:   r_pulse_width <= i_cfg.data[15:0];
                    CFG_VOLUME:  r_volume      <= i_cfg.data[15:0];
                    CFG_SUSTAIN: r_sustain     <= i_cfg.data[ENV_W-1:0];
                    CFG_ATTACK:  r_attack      <= i_cfg.data[RATE_W-1:0];
                    CFG_DECAY:   r_decay       <= i_cfg.data[RATE_W-1:0];
                    CFG_RELEASE: r_release     <= i_cfg.data[RATE_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == ST_IDLE && i_req.valid) begin
                case (i_req.req_type)
                    REQ_NOTE_ON: begin
                        r_step  <= w_step;
                        r_stage <= ENV_ATTACK;
                        r_prog  <= '0;
                    end
                    REQ_NOTE_OFF: begin
                        if (r_stage != ENV_IDLE && r_stage != ENV_RELEASE) begin
                            r_rel_start <= r_env_value;
                            r_stage     <= ENV_RELEASE;
                            r_prog      <= '0;
                        end
                    end
                    default: ;
                endcase
            end

            if (r_state == ST_SCALE && w_has_rate) begin
                r_prog <= w_prog_next;
            end

            if (r_state == ST_DONE && w_out_free) begin
                r_phase <= r_phase + r_step;
                if (w_has_rate && r_prog[PROG_FRAC]) begin
                    r_prog <= '0;
                    case (r_stage)
                        ENV_ATTACK: begin
                            r_stage     <= ENV_DECAY;
                            r_env_value <= ENV_FULL;
                        end
                        ENV_DECAY: begin
                            r_stage     <= ENV_SUSTAIN;
                            r_env_value <= r_sustain;
                        end
                        default: begin
                            r_stage     <= ENV_IDLE;
                            r_env_value <= '0;
                        end
                    endcase
                end else begin
                    r_env_value <= w_env_now;
                end
            end

            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_smp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_ENV: begin
                r_mag <= w_mag;
                r_neg <= w_wave[17];
            end
            ST_SQ: r_env <= w_env_now;
            ST_P1: r_t2 <= w_sh14[14:0];
            ST_P6: begin
                r_mag <= (w_amp > SIN_AMP) ? SIN_AMP[15:0] : w_amp[15:0];
                r_neg <= w_u[15];
            end
            ST_SCALE: r_sample <= r_neg ? (16'd0 - w_scaled) : w_scaled;
            ST_DONE: begin
                if (w_out_free) begin
                    r_out_sample <= r_sample;
                    r_out_env    <= r_env;
                    r_out_stage  <= r_stage;
                end
            end
            default: ;
        endcase
    end

endmodule

[sv/oadsr_mul.sv]
module oadsr_mul import oadsr_pkg::*; (
    input  logic               i_clk,
    input  t_mul_op            i_op,
    output logic [MUL_P_W-1:0] o_prod
);

    logic [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(i_op.a) * MUL_P_W'(i_op.b);
    end

    assign o_prod = r_prod;

endmodule

[tb/oscillator_with_adsr_envelope_test.sv]
`timescale 1ns / 1ps

module oscillator_with_adsr_envelope_test;
    import oadsr_pkg::*;

    localparam logic [1:0]           REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [SMP_W-1:0] smp;
        logic [ENV_W-1:0]        lvl;
        logic [2:0]              stg;
    } t_sample;

    class voice_tracker;
        logic [2:0]            wave_sel;
        logic [15:0]           pulse_w;
        logic [15:0]           gain;
        logic [15:0]           sustain;
        logic [RATE_W-1:0]     atk_rate;
        logic [RATE_W-1:0]     dec_rate;
        logic [RATE_W-1:0]     rel_rate;
        logic [PHASE_BITS-1:0] phase;
        logic [PHASE_BITS-1:0] step;
        t_env_stage            stage;
        logic [ENV_W-1:0]      env;
        logic [PROG_W-1:0]     prog;
        logic [ENV_W-1:0]      rel_start;
        t_sample               pending_samples[$];
        int                    errors;

        function new();
            wave_sel  = WAVE_SINE;
            pulse_w   = 16'd32768;
            gain      = 16'd32768;
            sustain   = 16'd45875;
            atk_rate  = 24'd1000;
            dec_rate  = 24'd1000;
            rel_rate  = 24'd500;
            phase     = '0;
            step      = '0;
            stage     = ENV_IDLE;
            env       = '0;
            prog      = '0;
            rel_start = '0;
            errors    = 0;
        endfunction

        task report(string what);
            if (errors < 100) $display("mismatch: %s", what);
            errors++;
        endtask

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_WAVE:    wave_sel = val[2:0];
                CFG_PULSE:   pulse_w  = val[15:0];
                CFG_VOLUME:  gain     = val[15:0];
                CFG_SUSTAIN: sustain  = val[15:0];
                CFG_ATTACK:  atk_rate = val[23:0];
                CFG_DECAY:   dec_rate = val[23:0];
                CFG_RELEASE: rel_rate = val[23:0];
                default: ;
            endcase
        endfunction

        function logic [ENV_W-1:0] level_now();
            bit [63:0] p;
            bit [63:0] e;
            bit [63:0] full;
            p = (prog > PROG_ONE) ? PROG_ONE : prog;
            e = env;
            full = ENV_FULL;
            case (stage)
                ENV_ATTACK:  return ENV_W'(e + (((full - e) * p) >> 24));
                ENV_DECAY:   return ENV_W'(full - (((full - 64'(sustain)) * p) >> 24));
                ENV_SUSTAIN: return sustain;
                ENV_RELEASE: return ENV_W'((64'(rel_start) * (64'(PROG_ONE) - p)) >> 24);
                default:     return '0;
            endcase
        endfunction

        function int sine_now();
            bit [63:0] idx, u, q, f, t, t2, poly, s, a;
            idx  = (64'(phase) * SINE_TABLE_DEPTH) >> PHASE_BITS;
            u    = (idx << 16) / SINE_TABLE_DEPTH;
            q    = (u >> 14) & 64'd3;
            f    = u & 64'h3FFF;
            t    = q[0] ? (64'd16384 - f) : f;
            t2   = (t * t) >> 14;
            poly = 64'(SIN_C2) - ((t2 * 64'(SIN_C3)) >> 14);
            poly = 64'(SIN_C1) - ((t2 * poly) >> 14);
            poly = 64'(SIN_C0) - ((t2 * poly) >> 14);
            s    = (t * poly) >> 14;
            a    = (s * 64'(SIN_AMP) + 64'd32768) >> 16;
            if (a > 64'd32767) a = 64'd32767;
            return (q >= 64'd2) ? -int'(a) : int'(a);
        endfunction

        function int wave_now();
            int p;
            int v;
            p = phase[PHASE_BITS-1 -: 16];
            case (wave_sel)
                WAVE_SINE:   return sine_now();
                WAVE_TRI: begin
                    v = (p < 32768) ? (2 * p - 32768) : (98304 - 2 * p);
                    return (v > 32767) ? 32767 : v;
                end
                WAVE_SQUARE: return (p < 32768) ? 32767 : -32767;
                WAVE_SAW:    return p - 32768;
                WAVE_PULSE:  return (p < int'(pulse_w)) ? 32767 : -32767;
                default:     return 0;
            endcase
        endfunction

        function void advance_env();
            logic [RATE_W-1:0] r;
            if (stage == ENV_ATTACK) r = atk_rate;
            else if (stage == ENV_DECAY) r = dec_rate;
            else if (stage == ENV_RELEASE) r = rel_rate;
            else begin
                env = level_now();
                return;
            end
            if (r == '0) prog = PROG_ONE;
            else prog = prog + PROG_W'(r);
            if (prog > PROG_ONE) prog = PROG_ONE;
            env = level_now();
            if (prog >= PROG_ONE) begin
                prog = '0;
                if (stage == ENV_ATTACK) begin
                    stage = ENV_DECAY;
                    env = ENV_FULL;
                end else if (stage == ENV_DECAY) begin
                    stage = ENV_SUSTAIN;
                    env = sustain;
                end else begin
                    stage = ENV_IDLE;
                    env = '0;
                end
            end
        endfunction

        function void take_request(logic [1:0] kind, logic [STEP_W-1:0] new_step);
            t_sample   e;
            int        w;
            bit [63:0] mag;
            bit [63:0] m;
            int        s;
            case (kind)
                REQ_NOTE_ON: begin
                    step  = PHASE_BITS'((64'(new_step) << 8) >> (32 - PHASE_BITS));
                    stage = ENV_ATTACK;
                    prog  = '0;
                end
                REQ_NOTE_OFF: begin
                    if (stage != ENV_IDLE && stage != ENV_RELEASE) begin
                        rel_start = env;
                        stage     = ENV_RELEASE;
                        prog      = '0;
                    end
                end
                REQ_TICK: begin
                    e.lvl = level_now();
                    e.stg = stage;
                    w     = wave_now();
                    mag   = (w < 0) ? -w : w;
                    m     = (mag * 64'(gain) * 64'(e.lvl)) >> 32;
                    s     = (w < 0) ? -int'(m) : int'(m);
                    e.smp = s[SMP_W-1:0];
                    pending_samples.push_back(e);
                    phase = phase + step;
                    advance_env();
                end
                default: ;
            endcase
        endfunction

        task check_sample(logic signed [SMP_W-1:0] s, logic [ENV_W-1:0] l, logic [2:0] g);
            t_sample e;
            if (pending_samples.size() == 0) begin
                report($sformatf("sample beat %0d with none expected", s));
                return;
            end
            e = pending_samples.pop_front();
            if (s !== e.smp) report($sformatf("sample %0d, expected %0d", s, e.smp));
            if (l !== e.lvl) report($sformatf("env level %0d, expected %0d", l, e.lvl));
            if (g !== e.stg) report($sformatf("env stage %0d, expected %0d", g, e.stg));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    oadsr_req_if req_bus();
    oadsr_smp_if smp_bus();
    oadsr_cfg_if cfg_bus();

    voice_tracker voice;
    int           src_odds = 0;
    int           snk_odds = 0;
    bit           hold_off = 1'b0;

    oscillator_with_adsr_envelope DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_smp   (smp_bus),
        .i_cfg   (cfg_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5000000;
        $display("[oscillator_with_adsr_envelope] ERROR");
        $finish;
    end

    initial begin : sample_sink
        int stall;
        stall = 0;
        smp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && smp_bus.valid && smp_bus.ready)
                voice.check_sample(smp_bus.sample_out, smp_bus.env_level, smp_bus.env_stage);
            if (hold_off) begin
                hold_off = 1'b0;
                stall = 300;
            end else if (stall == 0 && snk_odds != 0 && $urandom_range(1, snk_odds) == 1) begin
                stall = $urandom_range(1, 15);
            end
            if (stall > 0) begin
                stall--;
                smp_bus.ready <= 1'b0;
            end else begin
                smp_bus.ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        voice.set_reg(idx, val);
    endtask

    task automatic apply_setup(input logic [2:0] wave, input logic [15:0] pw,
                               input logic [15:0] vol, input logic [15:0] sus,
                               input logic [23:0] atk, input logic [23:0] dec,
                               input logic [23:0] rel, input logic [7:0] which);
        if (which[0]) write_reg(CFG_WAVE, {21'($urandom), wave});
        if (which[1]) write_reg(CFG_PULSE, {8'($urandom), pw});
        if (which[2]) write_reg(CFG_VOLUME, {8'($urandom), vol});
        if (which[3]) write_reg(CFG_SUSTAIN, {8'($urandom), sus});
        if (which[4]) write_reg(CFG_ATTACK, atk);
        if (which[5]) write_reg(CFG_DECAY, dec);
        if (which[6]) write_reg(CFG_RELEASE, rel);
        if (which[7]) write_reg(CFG_UNUSED, 24'($urandom));
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_req(input logic [1:0] kind, input logic [STEP_W-1:0] s);
        if (src_odds != 0 && $urandom_range(1, src_odds) == 1) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        req_bus.valid           <= 1'b1;
        req_bus.req_type        <= kind;
        req_bus.note_phase_step <= s;
        do @(posedge i_clk); while (!req_bus.ready);
        voice.take_request(kind, s);
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        while (voice.pending_samples.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_rate();
        case ($urandom_range(0, 9))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom_range(1, 4000));
            3:       return 24'($urandom);
            default: return 24'($urandom_range(1 << 19, 1 << 22));
        endcase
    endfunction

    initial begin : stimulus
        int          ph;
        int          n;
        int          k;
        logic [1:0]  kind;
        logic [22:0] s;
        logic [3:0]  w;

        req_bus.valid           <= 1'b0;
        req_bus.req_type        <= REQ_TICK;
        req_bus.note_phase_step <= '0;
        cfg_bus.valid           <= 1'b0;
        cfg_bus.index           <= CFG_WAVE;
        cfg_bus.data            <= '0;
        i_rst_n                 <= 1'b0;
        voice = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apply_setup(WAVE_SAW, 16'hFFFF, 16'hFFFF, 16'h0000, 24'd0, 24'd0, 24'd0, 8'hFF);
        send_req(REQ_TICK, 23'd0);
        send_req(REQ_NOTE_OFF, 23'd0);
        send_req(REQ_UNUSED, 23'h7FFFFF);
        send_req(REQ_NOTE_ON, 23'h7FFFFF);
        send_req(REQ_TICK, 23'd0);
        send_req(REQ_TICK, 23'd0);
        send_req(REQ_TICK, 23'd0);
        send_req(REQ_NOTE_OFF, 23'd0);
        send_req(REQ_TICK, 23'd0);
        send_req(REQ_NOTE_OFF, 23'd0);
        send_req(REQ_TICK, 23'd0);
        drain();

        apply_setup(3'd7, 16'h0000, 16'h0000, 16'hFFFF,
                    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'h7F);
        send_req(REQ_NOTE_ON, 23'd0);
        send_req(REQ_TICK, 23'h7FFFFF);
        send_req(REQ_TICK, 23'h7FFFFF);
        send_req(REQ_NOTE_OFF, 23'h7FFFFF);
        send_req(REQ_NOTE_OFF, 23'd0);
        send_req(REQ_TICK, 23'd0);
        send_req(REQ_TICK, 23'd0);
        send_req(REQ_TICK, 23'd0);
        drain();

        apply_setup(WAVE_SINE, 16'd32768, 16'hFFFF, 16'd40000,
                    24'd4194304, 24'd4194304, 24'd4194304, 8'h7F);
        send_req(REQ_NOTE_ON, 23'd1048576);
        repeat (5) send_req(REQ_TICK, 23'd0);
        drain();

        for (ph = 0; ph < 10; ph++) begin
            w = 4'($urandom_range(0, 15));
            apply_setup((w < 4'd13) ? 3'(w % 5) : 3'(w - 4'd8), pick_level(), pick_level(),
                        pick_level(), pick_rate(), pick_rate(), pick_rate(),
                        8'($urandom) | 8'h01);
            if (ph == 9) begin
                src_odds = 0;
                snk_odds = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       src_odds = 0;
                    1:       src_odds = 3;
                    default: src_odds = 10;
                endcase
                case ($urandom_range(0, 2))
                    0:       snk_odds = 0;
                    1:       snk_odds = 3;
                    default: snk_odds = 10;
                endcase
            end
            if (ph == 2) hold_off = 1'b1;
            n = 0;
            while (n < 80) begin
                k = $urandom_range(0, 99);
                if (k < 68) kind = REQ_TICK;
                else if (k < 80) kind = REQ_NOTE_ON;
                else if (k < 93) kind = REQ_NOTE_OFF;
                else kind = REQ_UNUSED;
                case ($urandom_range(0, 15))
                    0:       s = 23'd0;
                    1:       s = 23'h7FFFFF;
                    2:       s = 23'($urandom_range(1, 200000));
                    default: s = 23'($urandom);
                endcase
                send_req(kind, s);
                if (kind != REQ_UNUSED) n++;
            end
            drain();
        end

        if (voice.pending_samples.size() != 0)
            voice.report($sformatf("%0d samples never arrived", voice.pending_samples.size()));
        if (voice.errors == 0) begin
            $display("[oscillator_with_adsr_envelope] OK");
        end else begin
            $display("[oscillator_with_adsr_envelope] ERROR");
        end
        $finish;
    end

endmodule

[files.f]
sv/oadsr_pkg.sv
sv/oadsr_if.sv
sv/oadsr_mul.sv
sv/oscillator_with_adsr_envelope.sv
tb/oscillator_with_adsr_envelope_test.sv
